// File: hw/rtl/wrmswf_pkg.sv
package wrmswf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int RMS_W       = 17;
    localparam int NUM_TAPS    = 5;
    localparam int WINDOW_TAPS = 5;
    localparam bit USE_OUTER   = (WINDOW_TAPS >= 5);
    localparam int HIST_DEPTH  = NUM_TAPS - 1;
    localparam int EXT_DEPTH   = NUM_TAPS + 2;
    localparam int NUM_JOBS    = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam int TAP_W = $clog2(NUM_TAPS);
    localparam int CNT_W = $clog2(NUM_TAPS + 2);

    localparam int SQ_W       = 2 * SAMPLE_W - 1;
    localparam int PROD_W     = SQ_W + WEIGHT_W - 1;
    localparam int ACC_W      = PROD_W + 3;
    localparam int RAD_W      = ACC_W + (ACC_W % 2);
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int REM_W      = ROOT_W + 2;
    localparam int STEP_W     = $clog2(SQRT_STEPS);
    localparam int RMS_SHIFT  = 8;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OLDEST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BEFORE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTRE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AFTER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEWEST = 3'd4;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd13107;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [NUM_TAPS-1:0] t_window;
    typedef logic [WEIGHT_W-1:0] t_weight;
    typedef t_weight [NUM_TAPS-1:0] t_weights;

    typedef struct packed {
        t_window window;
        logic    frame_end;
    } t_job;

    function automatic logic [SQ_W-1:0] square_mag(input t_sample s);
        logic [SAMPLE_W-1:0]   mag;
        logic [2*SAMPLE_W-1:0] full;
        mag  = s[SAMPLE_W-1] ? (~s + 1'b1) : s;
        full = mag * mag;
        return full[SQ_W-1:0];
    endfunction

endpackage

// File: hw/rtl/wrmswf_front.sv
module wrmswf_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  wrmswf_pkg::t_sample i_sample,
    input  logic               i_last,
    output logic               o_ready,
    output logic               o_job_valid,
    input  logic               i_job_ready,
    output wrmswf_pkg::t_job   o_job
);

    wrmswf_pkg::t_sample r_hist [wrmswf_pkg::HIST_DEPTH];
    wrmswf_pkg::t_sample r_ext  [wrmswf_pkg::EXT_DEPTH];
    logic [1:0]                          r_fill;
    logic [wrmswf_pkg::NUM_JOBS-1:0]     r_mask;
    logic [wrmswf_pkg::NUM_JOBS-1:0]     r_endm;
    logic                                w_fire;
    logic                                w_shift;

    always_comb begin
        o_ready     = (r_mask == '0);
        w_fire      = i_valid && o_ready;
        w_shift     = (r_mask != '0) && (!r_mask[0] || i_job_ready);
        o_job_valid = r_mask[0];
        for (int k = 0; k < wrmswf_pkg::NUM_TAPS; k++) begin
            o_job.window[k] = r_ext[k];
        end
        o_job.frame_end = r_endm[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wrmswf_pkg::HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_fill <= '0;
            r_mask <= '0;
            r_endm <= '0;
        end else if (w_fire) begin
            for (int k = 0; k < wrmswf_pkg::HIST_DEPTH; k++) begin
                r_ext[k] <= r_hist[k];
            end
            r_ext[wrmswf_pkg::HIST_DEPTH]     <= i_sample;
            r_ext[wrmswf_pkg::HIST_DEPTH + 1] <= '0;
            r_ext[wrmswf_pkg::HIST_DEPTH + 2] <= '0;
            // Full window once the history holds two samples; a flush adds up to two trailing centres.
            r_mask <= {i_last, i_last && (r_fill != 2'd0), r_fill[1]};
            r_endm <= {i_last, 1'b0, 1'b0};
            if (i_last) begin
                for (int k = 0; k < wrmswf_pkg::HIST_DEPTH; k++) begin
                    r_hist[k] <= '0;
                end
                r_fill <= '0;
            end else begin
                for (int k = 0; k < wrmswf_pkg::HIST_DEPTH - 1; k++) begin
                    r_hist[k] <= r_hist[k+1];
                end
                r_hist[wrmswf_pkg::HIST_DEPTH-1] <= i_sample;
                if (!r_fill[1]) begin
                    r_fill <= r_fill + 2'd1;
                end
            end
        end else if (w_shift) begin
            for (int k = 0; k < wrmswf_pkg::EXT_DEPTH - 1; k++) begin
                r_ext[k] <= r_ext[k+1];
            end
            r_ext[wrmswf_pkg::EXT_DEPTH-1] <= '0;
            r_mask <= r_mask >> 1;
            r_endm <= r_endm >> 1;
        end
    end

endmodule

// File: hw/rtl/wrmswf_queue.sv
module wrmswf_queue #(
    parameter int DEPTH = wrmswf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  wrmswf_pkg::t_job i_wr_job,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output wrmswf_pkg::t_job o_rd_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    wrmswf_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        o_wr_ready = (r_count != FULL_CNT);
        o_rd_valid = (r_count != '0);
        o_rd_job   = r_mem[r_rd_ptr];
        w_push     = i_wr_valid && o_wr_ready;
        w_pop      = o_rd_valid && i_rd_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wr_ptr] <= i_wr_job;
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/wrmswf_back.sv
module wrmswf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_job_valid,
    output logic                              o_job_ready,
    input  wrmswf_pkg::t_job                  i_job,
    input  wrmswf_pkg::t_weights              i_weights,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [wrmswf_pkg::RMS_W-1:0]      o_rms,
    output logic                              o_frame_end
);

    typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_SQRT, ST_DONE} t_state;

    localparam logic [wrmswf_pkg::CNT_W-1:0] TAPS_END =
        wrmswf_pkg::CNT_W'(wrmswf_pkg::NUM_TAPS);
    localparam logic [wrmswf_pkg::CNT_W-1:0] MAC_END =
        wrmswf_pkg::CNT_W'(wrmswf_pkg::NUM_TAPS + 1);
    localparam logic [wrmswf_pkg::CNT_W-1:0] ACC_START =
        wrmswf_pkg::CNT_W'(2);
    localparam logic [wrmswf_pkg::TAP_W-1:0] TAP_OUTER =
        wrmswf_pkg::TAP_W'(wrmswf_pkg::NUM_TAPS - 1);
    localparam logic [wrmswf_pkg::STEP_W-1:0] STEP_END =
        wrmswf_pkg::STEP_W'(wrmswf_pkg::SQRT_STEPS - 1);

    t_state                                r_state;
    wrmswf_pkg::t_window                   r_win;
    logic                                  r_end;
    logic [wrmswf_pkg::CNT_W-1:0]          r_cnt;
    logic [wrmswf_pkg::TAP_W-1:0]          r_sq_k;
    logic [wrmswf_pkg::SQ_W-1:0]           r_sq;
    logic [wrmswf_pkg::PROD_W-1:0]         r_prod;
    logic [wrmswf_pkg::ACC_W-1:0]          r_acc;
    logic [wrmswf_pkg::RAD_W-1:0]          r_rad;
    logic [wrmswf_pkg::REM_W-1:0]          r_rem;
    logic [wrmswf_pkg::ROOT_W-1:0]         r_root;
    logic [wrmswf_pkg::STEP_W-1:0]         r_step;
    logic                                  r_out_valid;
    logic [wrmswf_pkg::RMS_W-1:0]          r_out_rms;
    logic                                  r_out_end;

    wrmswf_pkg::t_weight                   w_weight;
    logic [wrmswf_pkg::SQ_W+wrmswf_pkg::WEIGHT_W-1:0] w_prod_full;
    logic [wrmswf_pkg::ACC_W-1:0]          n_acc;
    logic [wrmswf_pkg::REM_W+1:0]          w_try;
    logic [wrmswf_pkg::REM_W+1:0]          w_trial;
    logic [wrmswf_pkg::REM_W+1:0]          w_diff;
    logic                                  w_ge;
    logic [wrmswf_pkg::REM_W-1:0]          n_rem;
    logic [wrmswf_pkg::ROOT_W-1:0]         n_root;

    always_comb begin
        o_job_ready = (r_state == ST_IDLE);
        o_valid     = r_out_valid;
        o_rms       = r_out_rms;
        o_frame_end = r_out_end;

        w_weight = i_weights[r_sq_k];
        if (!wrmswf_pkg::USE_OUTER && (r_sq_k == '0 || r_sq_k == TAP_OUTER)) begin
            w_weight = '0;
        end
        w_prod_full = r_sq * w_weight;
        n_acc       = r_acc + wrmswf_pkg::ACC_W'(r_prod);

        w_try   = {r_rem, r_rad[wrmswf_pkg::RAD_W-1 -: 2]};
        w_trial = {2'b00, r_root, 2'b01};
        w_diff  = w_try - w_trial;
        w_ge    = (w_try >= w_trial);
        n_rem   = w_ge ? w_diff[wrmswf_pkg::REM_W-1:0] : w_try[wrmswf_pkg::REM_W-1:0];
        n_root  = {r_root[wrmswf_pkg::ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_win   <= i_job.window;
                        r_end   <= i_job.frame_end;
                        r_cnt   <= '0;
                        r_acc   <= '0;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    // Square, weight and accumulate run as three stages.
                    if (r_cnt < TAPS_END) begin
                        r_sq   <= wrmswf_pkg::square_mag(r_win[r_cnt[wrmswf_pkg::TAP_W-1:0]]);
                        r_sq_k <= r_cnt[wrmswf_pkg::TAP_W-1:0];
                    end
                    if (r_cnt != '0 && r_cnt <= TAPS_END) begin
                        r_prod <= w_prod_full[wrmswf_pkg::PROD_W-1:0];
                    end
                    if (r_cnt >= ACC_START) begin
                        r_acc <= n_acc;
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == MAC_END) begin
                        r_rad   <= wrmswf_pkg::RAD_W'(n_acc);
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_step  <= '0;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_rem  <= n_rem;
                    r_root <= n_root;
                    r_rad  <= r_rad << 2;
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_END) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_rms   <= r_root[wrmswf_pkg::RMS_SHIFT +: wrmswf_pkg::RMS_W];
                        r_out_end   <= r_end;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hw/rtl/weighted_rms_window_filter.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: sample; tlast: last_in_frame
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: rms_value; tlast: frame_end
// cfg       in   i_cfg_we                         i_cfg_index, i_cfg_data (weights)
//
// The back end takes one window at a time: it takes a window, runs the square, weight
// and accumulate pipeline, then the 25 steps of the bit-serial square root, which sets
// the pace, and loads the output word. A frame end costs up to three results.
// The front end hands out up to three windows per sample and takes no new sample until
// they are out; the window queue lets it take new samples while the back end is busy.
// Reset is synchronous and loads default weights. The output word holds while tready is low.
module weighted_rms_window_filter #(
    parameter int QUEUE_DEPTH = wrmswf_pkg::QUEUE_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // sample [15:0]
    input  logic [wrmswf_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    input  logic                                   i_s_axis_tlast,
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    // rms_value [16:0], zero [23:17]
    output logic [wrmswf_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic                                   o_m_axis_tlast,
    input  logic                                   i_cfg_we,
    input  logic [wrmswf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wrmswf_pkg::WEIGHT_W-1:0]        i_cfg_data
);

    wrmswf_pkg::t_weights              r_weights;
    wrmswf_pkg::t_job                  w_front_job;
    wrmswf_pkg::t_job                  w_back_job;
    logic                              w_front_valid;
    logic                              w_front_ready;
    logic                              w_back_valid;
    logic                              w_back_ready;
    logic [wrmswf_pkg::RMS_W-1:0]      w_rms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < wrmswf_pkg::NUM_TAPS; k++) begin
                r_weights[k] <= wrmswf_pkg::WEIGHT_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wrmswf_pkg::REG_WEIGHT_OLDEST: begin
                    r_weights[wrmswf_pkg::REG_WEIGHT_OLDEST] <= i_cfg_data;
                end
                wrmswf_pkg::REG_WEIGHT_BEFORE: begin
                    r_weights[wrmswf_pkg::REG_WEIGHT_BEFORE] <= i_cfg_data;
                end
                wrmswf_pkg::REG_WEIGHT_CENTRE: begin
                    r_weights[wrmswf_pkg::REG_WEIGHT_CENTRE] <= i_cfg_data;
                end
                wrmswf_pkg::REG_WEIGHT_AFTER: begin
                    r_weights[wrmswf_pkg::REG_WEIGHT_AFTER] <= i_cfg_data;
                end
                wrmswf_pkg::REG_WEIGHT_NEWEST: begin
                    r_weights[wrmswf_pkg::REG_WEIGHT_NEWEST] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    wrmswf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_sample    (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_ready     (o_s_axis_tready),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    wrmswf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_job   (w_front_job),
        .o_rd_valid (w_back_valid),
        .i_rd_ready (w_back_ready),
        .o_rd_job   (w_back_job)
    );

    wrmswf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_back_valid),
        .o_job_ready (w_back_ready),
        .i_job       (w_back_job),
        .i_weights   (r_weights),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_rms       (w_rms),
        .o_frame_end (o_m_axis_tlast)
    );

    assign o_m_axis_tdata =
        {{(wrmswf_pkg::OUT_TDATA_W - wrmswf_pkg::RMS_W){1'b0}}, w_rms};

endmodule

// File: hw/rtl/wrmswf_checker.sv
module wrmswf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic                                i_s_axis_tlast,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [wrmswf_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input logic                                o_m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output word changed while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            o_m_axis_tdata[wrmswf_pkg::OUT_TDATA_W-1:wrmswf_pkg::RMS_W] == '0 &&
            o_m_axis_tdata[wrmswf_pkg::RMS_W-1:0] <= 17'd92682)
        else $error("result out of range");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_flush_busy: assert property (@(posedge i_clk)
        i_rst_n && i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast |=>
            !o_s_axis_tready)
        else $error("input taken during frame flush");

endmodule

bind weighted_rms_window_filter wrmswf_checker u_wrmswf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tlast  (i_s_axis_tlast),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: tb/tb_weighted_rms_window_filter.sv
`timescale 1ns / 1ps

module tb_weighted_rms_window_filter;

    localparam int SAMPLE_W    = wrmswf_pkg::SAMPLE_W;
    localparam int WEIGHT_W    = wrmswf_pkg::WEIGHT_W;
    localparam int RMS_W       = wrmswf_pkg::RMS_W;
    localparam int NUM_TAPS    = wrmswf_pkg::NUM_TAPS;
    localparam int HIST_DEPTH  = wrmswf_pkg::HIST_DEPTH;
    localparam int CFG_IDX_W   = wrmswf_pkg::CFG_IDX_W;
    localparam int IN_TDATA_W  = wrmswf_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W = wrmswf_pkg::OUT_TDATA_W;
    localparam int RMS_SHIFT   = wrmswf_pkg::RMS_SHIFT;
    localparam bit USE_OUTER   = wrmswf_pkg::USE_OUTER;

    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OLDEST = wrmswf_pkg::REG_WEIGHT_OLDEST;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_BEFORE = wrmswf_pkg::REG_WEIGHT_BEFORE;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTRE = wrmswf_pkg::REG_WEIGHT_CENTRE;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_AFTER  = wrmswf_pkg::REG_WEIGHT_AFTER;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_NEWEST = wrmswf_pkg::REG_WEIGHT_NEWEST;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_RESET      = wrmswf_pkg::WEIGHT_RESET;

    typedef wrmswf_pkg::t_sample t_sample;
    typedef wrmswf_pkg::t_weight t_weight;

    localparam int RANDOM_WORDS = 350;
    localparam int CFG_HOLDOFF  = 48;
    localparam int DRAIN_CYCLES = 120;
    localparam int IDLE_LIMIT   = 4000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic {ROW_SAMPLE, ROW_WEIGHT} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  last;
        logic                  typed;
        logic [1:0]            typed_n;
        logic [RMS_W-1:0]      typed_rms;
        logic [CFG_IDX_W-1:0]  index;
        logic [SAMPLE_W-1:0]   value;
    } t_dir_row;

    typedef struct packed {
        logic [RMS_W-1:0] rms;
        logic             frame_end;
    } t_result;

    localparam int DIR_ROWS = 33;
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{ROW_SAMPLE, 1'b1, 1'b1, 2'd1, 17'd0, REG_UNUSED, 16'h0000},
        '{ROW_SAMPLE, 1'b1, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h7FFF},
        '{ROW_SAMPLE, 1'b1, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h7FFF},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h7FFF},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h0001},
        '{ROW_SAMPLE, 1'b1, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'hFFFF},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_OLDEST, 16'hFFFF},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_BEFORE, 16'hFFFF},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_CENTRE, 16'hFFFF},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_AFTER,  16'hFFFF},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_NEWEST, 16'hFFFF},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b1, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_OLDEST, 16'h0000},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_NEWEST, 16'h0000},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h7FFF},
        '{ROW_SAMPLE, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h1234},
        '{ROW_SAMPLE, 1'b1, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_BEFORE, 16'h0000},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_CENTRE, 16'h0000},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_WEIGHT_AFTER,  16'h0000},
        '{ROW_SAMPLE, 1'b0, 1'b1, 2'd0, 17'd0, REG_UNUSED, 16'h7FFF},
        '{ROW_SAMPLE, 1'b0, 1'b1, 2'd0, 17'd0, REG_UNUSED, 16'h8000},
        '{ROW_SAMPLE, 1'b1, 1'b1, 2'd3, 17'd0, REG_UNUSED, 16'h7FFF},
        '{ROW_WEIGHT, 1'b0, 1'b0, 2'd0, 17'd0, REG_UNUSED, 16'hFFFF},
        '{ROW_SAMPLE, 1'b1, 1'b1, 2'd1, 17'd0, REG_UNUSED, 16'h8000}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    i_s_axis_tlast = 1'b0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    o_m_axis_tlast;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [WEIGHT_W-1:0]     i_cfg_data = '0;

    t_weight    tap_weight [NUM_TAPS] = '{default: WEIGHT_RESET};
    t_sample    history [HIST_DEPTH] = '{default: '0};
    int         fill_count = 0;
    t_result    pending_rms [$];
    t_result    rms_head;
    int         mismatches = 0;
    int         words_seen = 0;
    int         idle_cycles = 0;
    int         burst_left = 0;
    int         stall_mode = 0;
    int         mode_left = 0;
    int         stall_phase = 0;

    weighted_rms_window_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [RMS_W-1:0] rms_of_window(input t_sample win [NUM_TAPS]);
        longint signed   value;
        longint unsigned mag;
        longint unsigned acc;
        longint unsigned root;
        longint unsigned trial;
        acc = 0;
        for (int k = 0; k < NUM_TAPS; k++) begin
            if (USE_OUTER || (k != 0 && k != NUM_TAPS - 1)) begin
                value = longint'($signed(win[k]));
                mag   = (value < 0) ? -value : value;
                acc  += mag * mag * longint'(tap_weight[k]);
            end
        end
        root = 0;
        for (int b = 27; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= acc) begin
                root = trial;
            end
        end
        return RMS_W'(root >> RMS_SHIFT);
    endfunction

    function automatic int advance_filter(input t_sample x, input logic last,
                                          output t_result res [3]);
        t_sample win [NUM_TAPS];
        t_sample ext [NUM_TAPS + 2];
        int      have;
        int      n;
        have = fill_count + 1;
        n    = 0;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            win[k] = history[k];
        end
        win[NUM_TAPS-1] = x;
        if (have >= 3) begin
            res[n] = '{rms: rms_of_window(win), frame_end: 1'b0};
            n++;
        end
        if (!last) begin
            for (int k = 0; k < HIST_DEPTH - 1; k++) begin
                history[k] = history[k+1];
            end
            history[HIST_DEPTH-1] = x;
            if (fill_count < 2) begin
                fill_count++;
            end
            return n;
        end
        for (int k = 0; k < NUM_TAPS; k++) begin
            ext[k] = win[k];
        end
        ext[NUM_TAPS]   = '0;
        ext[NUM_TAPS+1] = '0;
        if (have >= 2) begin
            for (int k = 0; k < NUM_TAPS; k++) begin
                win[k] = ext[k+1];
            end
            res[n] = '{rms: rms_of_window(win), frame_end: 1'b0};
            n++;
        end
        for (int k = 0; k < NUM_TAPS; k++) begin
            win[k] = ext[k+2];
        end
        res[n] = '{rms: rms_of_window(win), frame_end: 1'b1};
        n++;
        for (int k = 0; k < HIST_DEPTH; k++) begin
            history[k] = '0;
        end
        fill_count = 0;
        return n;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on word %0d, %s: got %0d, expected %0d", words_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_sample(input t_sample s, input logic last, input logic typed,
                               input int typed_n, input logic [RMS_W-1:0] typed_rms);
        t_result res [3];
        int      n;
        int      gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= s;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        n = advance_filter(s, last, res);
        if (typed) begin
            for (int k = 0; k < typed_n; k++) begin
                pending_rms.insert(pending_rms.size(),
                    '{rms: typed_rms, frame_end: last && (k == typed_n - 1)});
            end
        end else begin
            for (int k = 0; k < n; k++) begin
                pending_rms.insert(pending_rms.size(), res[k]);
            end
        end
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx, input t_weight w);
        i_s_axis_tvalid <= 1'b0;
        while (pending_rms.size() != 0) @(posedge i_clk);
        repeat (CFG_HOLDOFF) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (int'(idx) < NUM_TAPS) begin
            tap_weight[idx] = w;
        end
    endtask

    function automatic t_weight pick_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return WEIGHT_RESET;
            default: return t_weight'($urandom);
        endcase
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return t_sample'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= 1'($urandom_range(0, 1));
            2: i_m_axis_tready <= (stall_phase % 4) == 0;
            default: i_m_axis_tready <= $urandom_range(0, 7) != 0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_rms.size() == 0) begin
                report_mismatch("word with none pending", longint'(o_m_axis_tdata), -1);
            end else begin
                rms_head = pending_rms.pop_front();
                if (o_m_axis_tdata[RMS_W-1:0] != rms_head.rms) begin
                    report_mismatch("rms_value", longint'(o_m_axis_tdata[RMS_W-1:0]),
                                    longint'(rms_head.rms));
                end
                if (o_m_axis_tlast != rms_head.frame_end) begin
                    report_mismatch("frame_end", longint'(o_m_axis_tlast),
                                    longint'(rms_head.frame_end));
                end
                if (o_m_axis_tdata[OUT_TDATA_W-1:RMS_W] != '0) begin
                    report_mismatch("tdata padding",
                                    longint'(o_m_axis_tdata[OUT_TDATA_W-1:RMS_W]), 0);
                end
            end
            words_seen <= words_seen + 1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d words pending", pending_rms.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int sent;
        int frames;
        int frame_len;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_WEIGHT) begin
                write_weight(DIRECTED[r].index, DIRECTED[r].value);
            end else begin
                send_sample(DIRECTED[r].value, DIRECTED[r].last, DIRECTED[r].typed,
                            int'(DIRECTED[r].typed_n), DIRECTED[r].typed_rms);
            end
        end

        sent = 0;
        while (sent < RANDOM_WORDS) begin
            write_weight(REG_WEIGHT_OLDEST, pick_weight());
            write_weight(REG_WEIGHT_BEFORE, pick_weight());
            write_weight(REG_WEIGHT_CENTRE, pick_weight());
            write_weight(REG_WEIGHT_AFTER,  pick_weight());
            write_weight(REG_WEIGHT_NEWEST, pick_weight());
            if ($urandom_range(0, 2) == 0) begin
                write_weight(REG_WEIGHT_NEWEST + CFG_IDX_W'($urandom_range(1, 3)),
                             t_weight'($urandom));
            end
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
                frame_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                        : $urandom_range(3, 20);
                for (int i = 0; i < frame_len; i++) begin
                    send_sample(pick_sample(), i == frame_len - 1, 1'b0, 0, '0);
                    sent++;
                end
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_rms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/wrmswf_pkg.sv
hw/rtl/wrmswf_front.sv
hw/rtl/wrmswf_queue.sv
hw/rtl/wrmswf_back.sv
hw/rtl/weighted_rms_window_filter.sv
hw/rtl/wrmswf_checker.sv
tb/tb_weighted_rms_window_filter.sv
